// ----- src/pps_pkg.sv -----
// ----------------------------------------------------------------------------
// pps_pkg: shared types for the preemptive priority scheduler
// Input and result beat layouts and the opcode codes.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int unsigned OpBits = 1;
  localparam int unsigned SlotFieldBits = 4;
  localparam int unsigned FieldTimeBits = 16;
  localparam int unsigned PrioBits = 8;
  localparam int unsigned CountBits = 5;

  // slot table depth, tied to the slot field width
  localparam int unsigned MaxSlots = 16;

  typedef enum logic [OpBits-1:0] {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef struct packed {
    logic [OpBits-1:0]        opcode;
    logic [SlotFieldBits-1:0] slot;
    logic [FieldTimeBits-1:0] arrival;
    logic [FieldTimeBits-1:0] burst_len;
    logic [PrioBits-1:0]      prio;
  } in_beat_t;

  typedef struct packed {
    logic                     ran;
    logic [SlotFieldBits-1:0] ran_slot;
    logic                     finished;
    logic [FieldTimeBits-1:0] completion_time;
    logic [FieldTimeBits-1:0] turnaround;
    logic [FieldTimeBits-1:0] waiting;
    logic [FieldTimeBits-1:0] response;
    logic                     all_done;
    logic [FieldTimeBits-1:0] now;
    logic [FieldTimeBits-1:0] busy_ticks;
  } out_beat_t;

  // candidate travelling along the cell chain
  typedef struct packed {
    logic                found;
    logic [PrioBits-1:0] prio;
  } cand_t;

endpackage

// ----- src/pps_cell.sv -----
// ----------------------------------------------------------------------------
// pps_cell: one process slot of the scheduler chain
// Holds the slot's tables and flags. During a scan the slot word rotates
// through the chain one cell per cycle so one comparator at the head sees
// every slot in turn.
// ----------------------------------------------------------------------------
module pps_cell #(
  parameter int unsigned TIME_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   shift_i,
  input  logic                   load_i,
  input  logic [TIME_BITS-1:0]   arr_i,
  input  logic [TIME_BITS-1:0]   bur_i,
  input  logic [TIME_BITS-1:0]   rem_i,
  input  logic [TIME_BITS-1:0]   st_i,
  input  logic [pps_pkg::PrioBits-1:0] prio_i,
  input  logic                   started_i,
  input  logic                   done_i,
  output logic [TIME_BITS-1:0]   arr_o,
  output logic [TIME_BITS-1:0]   bur_o,
  output logic [TIME_BITS-1:0]   rem_o,
  output logic [TIME_BITS-1:0]   st_o,
  output logic [pps_pkg::PrioBits-1:0] prio_o,
  output logic                   started_o,
  output logic                   done_o
);
  import pps_pkg::*;

  logic [TIME_BITS-1:0] arr_q, bur_q, rem_q, st_q;
  logic [PrioBits-1:0]  prio_q;
  logic                 started_q, done_q;

  // take the neighbor's word on shift or a direct write on load
  always_ff @(posedge clk_i) begin
    if (shift_i || load_i) begin
      arr_q  <= arr_i;
      bur_q  <= bur_i;
      rem_q  <= rem_i;
      st_q   <= st_i;
      prio_q <= prio_i;
    end
  end

  // flags reset clean
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      done_q    <= 1'b0;
    end else if (shift_i || load_i) begin
      started_q <= started_i;
      done_q    <= done_i;
    end
  end

  assign arr_o     = arr_q;
  assign bur_o     = bur_q;
  assign rem_o     = rem_q;
  assign st_o      = st_q;
  assign prio_o    = prio_q;
  assign started_o = started_q;
  assign done_o    = done_q;

endmodule

// ----- src/preemptive_priority_scheduler_core.sv -----
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_core: preemptive priority scheduler
// Load beats fill a slot, tick beats run the best ready slot for one unit.
// ----------------------------------------------------------------------------
// A load beat is written on the cycle after it is accepted and its result is
// presented on the cycle after that. A tick beat rotates the slot words
// around a ring of MAX_SLOTS cells, one cell per cycle, past a single
// priority comparator at cell 0. The first rotation finds the winner, the
// second updates the winner's word as it passes and checks the done flags;
// the apply state then advances time and forms the result. The result sits
// in an output register; the next beat is taken once it has left, so a
// result stall holds off the next beat.
module preemptive_priority_scheduler_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [pps_pkg::CountBits-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  pps_pkg::in_beat_t          in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output pps_pkg::out_beat_t         out_data_o
);
  import pps_pkg::*;

  localparam int unsigned MAX_SLOTS = MaxSlots;
  localparam int unsigned TIME_BITS = FieldTimeBits;
  localparam int unsigned IdxBits = $clog2(MAX_SLOTS);
  localparam int unsigned CntBits = $clog2(MAX_SLOTS + 1);
  localparam int unsigned RotBits = $clog2(2 * MAX_SLOTS + 1);
  localparam logic [TIME_BITS-1:0] TimeMax = '1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_APPLY = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // ring wiring
  logic [TIME_BITS-1:0] arr_w [MAX_SLOTS], bur_w [MAX_SLOTS], rem_w [MAX_SLOTS];
  logic [TIME_BITS-1:0] st_w [MAX_SLOTS];
  logic [PrioBits-1:0]  prio_w [MAX_SLOTS];
  logic                 sta_w [MAX_SLOTS], dn_w [MAX_SLOTS];
  logic [TIME_BITS-1:0] arr_n [MAX_SLOTS], bur_n [MAX_SLOTS], rem_n [MAX_SLOTS];
  logic [TIME_BITS-1:0] st_n [MAX_SLOTS];
  logic [PrioBits-1:0]  prio_n [MAX_SLOTS];
  logic                 sta_n [MAX_SLOTS], dn_n [MAX_SLOTS];
  logic                 ld_w [MAX_SLOTS];
  logic                 shift;

  logic [CountBits-1:0] pcount_q;
  logic [CntBits-1:0]   n_use;
  logic [TIME_BITS-1:0] now_q, busy_q;
  logic [RotBits-1:0]   rot_q;
  logic                 pass2;
  logic [IdxBits-1:0]   head_idx;
  cand_t                best_q;
  logic [IdxBits-1:0]   best_idx_q;
  logic                 ndone_q;
  logic                 in_use, ready;
  out_beat_t            res_q;
  in_beat_t             beat_q;
  logic                 hit;
  logic                 ld_all_done;
  logic [TIME_BITS-1:0] now_inc, busy_inc, rem_dec, tat, ct;

  assign n_use = (pcount_q > CountBits'(MAX_SLOTS)) ? CntBits'(MAX_SLOTS)
                                                   : CntBits'(pcount_q);

  // rotation index: cell 0 holds slot head_idx
  assign pass2    = (rot_q >= RotBits'(MAX_SLOTS));
  assign head_idx = pass2 ? IdxBits'(rot_q - RotBits'(MAX_SLOTS)) : IdxBits'(rot_q);
  assign in_use   = ({1'b0, head_idx} < (IdxBits+1)'(n_use));
  assign ready    = in_use && !dn_w[0] && (arr_w[0] <= now_q);
  assign shift    = (state_q == ST_SCAN);
  assign hit      = pass2 && best_q.found && (head_idx == best_idx_q);

  assign now_inc  = (now_q == TimeMax) ? now_q : now_q + 1'b1;
  assign busy_inc = (busy_q == TimeMax) ? busy_q : busy_q + 1'b1;
  assign rem_dec  = (rem_w[0] != '0) ? rem_w[0] - 1'b1 : rem_w[0];
  assign ct       = now_inc;
  assign tat      = (ct > arr_w[0]) ? ct - arr_w[0] : '0;

  // ring links: cell i takes from cell i+1, cell 0 word (updated) goes last
  for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_ring
    if (g == MAX_SLOTS - 1) begin : g_tail
      always_comb begin
        arr_n[g] = arr_w[0];  bur_n[g] = bur_w[0];  prio_n[g] = prio_w[0];
        rem_n[g] = hit ? rem_dec : rem_w[0];
        st_n[g]  = (hit && !sta_w[0]) ? now_q : st_w[0];
        sta_n[g] = sta_w[0] || hit;
        dn_n[g]  = dn_w[0] || (hit && rem_dec == '0);
      end
    end else begin : g_mid
      always_comb begin
        arr_n[g] = arr_w[g+1]; bur_n[g] = bur_w[g+1]; prio_n[g] = prio_w[g+1];
        rem_n[g] = rem_w[g+1]; st_n[g] = st_w[g+1];
        sta_n[g] = sta_w[g+1]; dn_n[g] = dn_w[g+1];
      end
    end
    always_comb begin
      ld_w[g] = (state_q == ST_APPLY) && (beat_q.opcode == OP_LOAD) &&
                (beat_q.slot == SlotFieldBits'(g));
    end
    pps_cell #(.TIME_BITS(TIME_BITS)) u_cell (
      .clk_i, .rst_ni, .shift_i(shift), .load_i(ld_w[g]),
      .arr_i(ld_w[g] ? TIME_BITS'(beat_q.arrival) : arr_n[g]),
      .bur_i(ld_w[g] ? TIME_BITS'(beat_q.burst_len) : bur_n[g]),
      .rem_i(ld_w[g] ? TIME_BITS'(beat_q.burst_len) : rem_n[g]),
      .st_i(st_n[g]),
      .prio_i(ld_w[g] ? beat_q.prio : prio_n[g]),
      .started_i(ld_w[g] ? 1'b0 : sta_n[g]),
      .done_i(ld_w[g] ? 1'b0 : dn_n[g]),
      .arr_o(arr_w[g]), .bur_o(bur_w[g]), .rem_o(rem_w[g]), .st_o(st_w[g]),
      .prio_o(prio_w[g]), .started_o(sta_w[g]), .done_o(dn_w[g])
    );
  end

  // all_done after a load: the loaded slot counts as not done
  always_comb begin
    ld_all_done = 1'b1;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (i < int'(n_use) && (!dn_w[i] || beat_q.slot == SlotFieldBits'(i))) begin
        ld_all_done = 1'b0;
      end
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign out_data_o = res_q;

  // sequence one beat
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = (in_data_i.opcode == OP_TICK) ? ST_SCAN : ST_APPLY;
      ST_SCAN: if (rot_q == RotBits'(2 * MAX_SLOTS - 1)) state_d = ST_APPLY;
      ST_APPLY: state_d = ST_OUT;
      ST_OUT:  if (!out_stall_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) beat_q <= in_data_i;
  end

  // control, time and search registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pcount_q <= '0;
      now_q <= '0;
      busy_q <= '0;
      rot_q <= '0;
      best_q <= '0;
      best_idx_q <= '0;
      ndone_q <= 1'b0;
      res_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) pcount_q <= cfg_wdata_i;
      case (state_q)
        ST_IDLE: begin
          rot_q <= '0;
          best_q <= '0;
          ndone_q <= 1'b0;
          res_q <= '0;
        end
        ST_SCAN: begin
          rot_q <= rot_q + 1'b1;
          if (!pass2 && ready && (!best_q.found || prio_w[0] < best_q.prio)) begin
            best_q.found <= 1'b1;
            best_q.prio <= prio_w[0];
            best_idx_q <= head_idx;
          end
          // all_done after update: check words leaving in pass 2
          if (pass2 && in_use && !dn_n[MAX_SLOTS-1]) ndone_q <= 1'b1;
          if (hit) begin
            res_q.ran <= 1'b1;
            res_q.ran_slot <= SlotFieldBits'(head_idx);
            busy_q <= busy_inc;
            if (rem_dec == '0) begin
              res_q.finished <= 1'b1;
              res_q.completion_time <= FieldTimeBits'(ct);
              res_q.turnaround <= FieldTimeBits'(tat);
              res_q.waiting <= FieldTimeBits'((tat > bur_w[0]) ? tat - bur_w[0] : '0);
              res_q.response <= FieldTimeBits'((st_n[MAX_SLOTS-1] > arr_w[0]) ?
                                               st_n[MAX_SLOTS-1] - arr_w[0] : '0);
            end
          end
        end
        ST_APPLY: begin
          if (beat_q.opcode == OP_TICK) begin
            now_q <= now_inc;
            res_q.now <= FieldTimeBits'(now_inc);
            res_q.all_done <= !ndone_q;
          end else begin
            res_q.now <= FieldTimeBits'(now_q);
            res_q.all_done <= ld_all_done;
          end
          res_q.busy_ticks <= FieldTimeBits'(busy_q);
        end
        default: ;
      endcase
    end
  end

  // hold the input off while a beat is in flight
  property p_stall_busy;
    @(posedge clk_i) disable iff (!rst_ni) (state_q != ST_IDLE) |-> in_stall_o;
  endproperty
  assert property (p_stall_busy) else $error("input taken while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && hit) |=> best_q.found)
    else $error("winner lost during scan");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_APPLY) |=> out_valid_o)
    else $error("result not presented after apply");

endmodule
